/* hw/rtl/vll_pkg.sv */
// ----------------------------------------------------------------------------
// vll_pkg: shared types and constants of the vector length limiter
// Fixed internal widths of the squared length, the root, the quotient
// chain, and the action codes.
// ----------------------------------------------------------------------------
package vll_pkg;

	// Length bounds and action field.
	localparam int LEN_W = 16;
	localparam int ACT_W = 2;
	localparam int IDX_W = 8;

	// Squared length: full sum and the saturated 64-bit value.
	localparam int SUM_W = 65;
	localparam int SQ_W  = 64;

	// Normalization: up to 31 double-bit shifts.
	localparam int K_W        = 5;
	localparam int NORM_STEPS = 31;

	// Square root: one result bit per cell.
	localparam int ROOT_W     = 32;
	localparam int ROOT_STEPS = 32;
	localparam int REM_W      = 34;

	// Division: quotient never exceeds the 16-bit target.
	localparam int NUM_W = 48;
	localparam int DVD_W = 50;
	localparam int DVS_W = 33;
	localparam int Q_W   = 17;
	localparam int LANES = 4;

	typedef logic [ACT_W-1:0] act_t;

	localparam act_t ACT_KEEP     = 2'd0;
	localparam act_t ACT_SHORTEN  = 2'd1;
	localparam act_t ACT_LENGTHEN = 2'd2;
	localparam act_t ACT_ZERO     = 2'd3;

	localparam logic [IDX_W-1:0] REG_MAX_LENGTH = 8'd0;
	localparam logic [IDX_W-1:0] REG_MIN_LENGTH = 8'd1;

	// Per-lane state of the quotient chain.
	typedef logic [LANES-1:0][DVS_W-1:0] lane_rem_t;
	typedef logic [LANES-1:0][Q_W-1:0]   lane_q_t;

endpackage

/* hw/rtl/vll_norm_cell.sv */
// ----------------------------------------------------------------------------
// vll_norm_cell: one normalization step
// Shifts the squared length left by two bits if its top two bits are
// clear, and counts the shift.
// ----------------------------------------------------------------------------
module vll_norm_cell #(
	parameter int SIDE_W = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid_i,
	input  logic [vll_pkg::SQ_W-1:0] sn_i,
	input  logic [vll_pkg::K_W-1:0]  k_i,
	input  logic [SIDE_W-1:0]        side_i,
	output logic                    valid_q,
	output logic [vll_pkg::SQ_W-1:0] sn_q,
	output logic [vll_pkg::K_W-1:0]  k_q,
	output logic [SIDE_W-1:0]        side_q
);
	import vll_pkg::*;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// Shift when the top two bits are clear.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (sn_i[SQ_W-1:SQ_W-2] == 2'b00) begin
				sn_q <= {sn_i[SQ_W-3:0], 2'b00};
				k_q  <= k_i + K_W'(1);
			end else begin
				sn_q <= sn_i;
				k_q  <= k_i;
			end
		end
	end

endmodule

/* hw/rtl/vll_root_cell.sv */
// ----------------------------------------------------------------------------
// vll_root_cell: one digit of the integer square root
// Takes the next two bits of the radicand and decides one root bit.
// ----------------------------------------------------------------------------
module vll_root_cell #(
	parameter int SIDE_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_i,
	input  logic [vll_pkg::SQ_W-1:0]   sn_i,
	input  logic [vll_pkg::REM_W-1:0]  rem_i,
	input  logic [vll_pkg::ROOT_W-1:0] root_i,
	input  logic [SIDE_W-1:0]          side_i,
	output logic                      valid_q,
	output logic [vll_pkg::SQ_W-1:0]   sn_q,
	output logic [vll_pkg::REM_W-1:0]  rem_q,
	output logic [vll_pkg::ROOT_W-1:0] root_q,
	output logic [SIDE_W-1:0]          side_q
);
	import vll_pkg::*;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;

	// Bring down two radicand bits and form the trial value.
	assign rem_sh = {rem_i[REM_W-3:0], sn_i[SQ_W-1:SQ_W-2]};
	assign trial  = {root_i, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// Restoring step.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			sn_q   <= {sn_i[SQ_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_i[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_i[ROOT_W-2:0], 1'b0};
			end
		end
	end

endmodule

/* hw/rtl/vll_div_cell.sv */
// ----------------------------------------------------------------------------
// vll_div_cell: one quotient bit for all four components
// Restoring division step shared by the four lanes against one divisor.
// ----------------------------------------------------------------------------
module vll_div_cell #(
	parameter int SIDE_W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid_i,
	input  logic [vll_pkg::DVS_W-1:0] dvs_i,
	input  vll_pkg::lane_rem_t        rem_i,
	input  vll_pkg::lane_q_t          lo_i,
	input  vll_pkg::lane_q_t          quo_i,
	input  logic [SIDE_W-1:0]         side_i,
	output logic                     valid_q,
	output logic [vll_pkg::DVS_W-1:0] dvs_q,
	output vll_pkg::lane_rem_t        rem_q,
	output vll_pkg::lane_q_t          lo_q,
	output vll_pkg::lane_q_t          quo_q,
	output logic [SIDE_W-1:0]         side_q
);
	import vll_pkg::*;

	logic [LANES-1:0][DVS_W:0] part;
	logic [LANES-1:0]          fits;

	// Bring down the next dividend bit and test against the divisor.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			part[i] = {rem_i[i], lo_i[i][Q_W-1]};
			fits[i] = part[i] >= {1'b0, dvs_i};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_q  <= dvs_i;
			side_q <= side_i;
			for (int i = 0; i < LANES; i++) begin
				lo_q[i]  <= {lo_i[i][Q_W-2:0], 1'b0};
				quo_q[i] <= {quo_i[i][Q_W-2:0], fits[i]};
				if (fits[i]) begin
					rem_q[i] <= DVS_W'(part[i] - {1'b0, dvs_i});
				end else begin
					rem_q[i] <= DVS_W'(part[i]);
				end
			end
		end
	end

endmodule

/* hw/rtl/vec4_length_limiter.sv */
// ----------------------------------------------------------------------------
// vec4_length_limiter: clamps the Euclidean length of a four-component vector
// Pipelined squared length, normalization, square root and division chains.
// ----------------------------------------------------------------------------
// Takes one vector per clock while the output is not stalled. It passes five
// front stages for squares, sum and bound tests, 31 normalization cells, 32
// square root cells, two stages that form the dividend, 17 quotient cells for
// all four components at once, and the output register. A stall on the output
// freezes the whole pipeline and is shown on in_stall in the same cycle. Length
// bounds are to be written through the cfg port while no vector is in flight;
// the block does not enforce this. Each bound's square is registered from it.
module vec4_length_limiter #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COMPONENT_BITS-1:0] in_x,
	input  logic signed [COMPONENT_BITS-1:0] in_y,
	input  logic signed [COMPONENT_BITS-1:0] in_z,
	input  logic signed [COMPONENT_BITS-1:0] in_w,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COMPONENT_BITS-1:0] out_x,
	output logic signed [COMPONENT_BITS-1:0] out_y,
	output logic signed [COMPONENT_BITS-1:0] out_z,
	output logic signed [COMPONENT_BITS-1:0] out_w,
	output logic [vll_pkg::ACT_W-1:0]      action,
	output logic                          saturated,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vll_pkg::IDX_W-1:0]      cfg_index,
	input  logic [vll_pkg::LEN_W-1:0]      cfg_data
);
	import vll_pkg::*;

	localparam int CB      = COMPONENT_BITS;
	localparam int SIDE0_W = 8 * CB + LANES + ACT_W + LEN_W;
	localparam int SIDE1_W = SIDE0_W + K_W;
	localparam int SIDE2_W = 4 * CB + LANES + ACT_W;
	localparam int LIM_W   = DVS_W;

	logic adv;
	logic out_valid_q;

	// Global advance: the pipeline moves unless a result is held.
	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// Length bound registers and their squares.
	logic [LEN_W-1:0]   max_len_q;
	logic [LEN_W-1:0]   min_len_q;
	logic [2*LEN_W-1:0] max_sq_q;
	logic [2*LEN_W-1:0] min_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '1;
			min_len_q <= '0;
			max_sq_q  <= 32'hFFFE_0001;
			min_sq_q  <= '0;
		end else begin
			if (cfg_valid && cfg_index == REG_MAX_LENGTH) begin
				max_len_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_MIN_LENGTH) begin
				min_len_q <= cfg_data;
			end
			max_sq_q <= (2*LEN_W)'(max_len_q) * (2*LEN_W)'(max_len_q);
			min_sq_q <= (2*LEN_W)'(min_len_q) * (2*LEN_W)'(min_len_q);
		end
	end

	// Stage 1: magnitudes and signs.
	logic [LANES-1:0][CB-1:0] in_vec;
	logic [LANES-1:0][CB-1:0] raw_s1, raw_s2, raw_s3, raw_s4;
	logic [LANES-1:0][CB-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [LANES-1:0]         neg_s1, neg_s2, neg_s3, neg_s4;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign in_vec = {in_w, in_x, in_y, in_z} == '0 ? '0 : {in_w, in_z, in_y, in_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				raw_s1[i] <= in_vec[i];
				neg_s1[i] <= in_vec[i][CB-1];
				mag_s1[i] <= in_vec[i][CB-1] ? CB'(~in_vec[i] + CB'(1)) : in_vec[i];
			end
		end
	end

	// Stage 2: squares.
	logic [LANES-1:0][2*CB-1:0] sq_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s2 <= raw_s1;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			for (int i = 0; i < LANES; i++) begin
				sq_s2[i] <= (2*CB)'(mag_s1[i]) * (2*CB)'(mag_s1[i]);
			end
		end
	end

	// Stage 3: pair sums.
	logic [1:0][SUM_W-1:0] ps_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s3   <= raw_s2;
			mag_s3   <= mag_s2;
			neg_s3   <= neg_s2;
			ps_s3[0] <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]);
			ps_s3[1] <= SUM_W'(sq_s2[2]) + SUM_W'(sq_s2[3]);
		end
	end

	// Stage 4: total, saturated to 64 bits.
	logic [SUM_W-1:0] tot;
	logic [SQ_W-1:0]  s_s4;

	assign tot = ps_s3[0] + ps_s3[1];

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s4 <= raw_s3;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			s_s4   <= tot[SUM_W-1] ? '1 : tot[SQ_W-1:0];
		end
	end

	// Stage 5: bound tests; the maximum test wins.
	act_t             act_c;
	logic [LEN_W-1:0] tgt_c;
	logic [SQ_W-1:0]  s_s5;
	logic [SIDE0_W-1:0] side0_s5;

	always_comb begin
		if (s_s4 > SQ_W'(max_sq_q)) begin
			act_c = ACT_SHORTEN;
			tgt_c = max_len_q;
		end else if (s_s4 < SQ_W'(min_sq_q)) begin
			act_c = (s_s4 == '0) ? ACT_ZERO : ACT_LENGTHEN;
			tgt_c = min_len_q;
		end else begin
			act_c = ACT_KEEP;
			tgt_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s5     <= s_s4;
			side0_s5 <= {raw_s4, mag_s4, neg_s4, act_c, tgt_c};
		end
	end

	// Normalization chain.
	logic [NORM_STEPS:0]              nv;
	logic [NORM_STEPS:0][SQ_W-1:0]    nsn;
	logic [NORM_STEPS:0][K_W-1:0]     nk;
	logic [NORM_STEPS:0][SIDE0_W-1:0] nside;

	assign nv[0]    = v_s5;
	assign nsn[0]   = s_s5;
	assign nk[0]    = '0;
	assign nside[0] = side0_s5;

	for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
		vll_norm_cell #(.SIDE_W(SIDE0_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.valid_i (nv[g]),
			.sn_i    (nsn[g]),
			.k_i     (nk[g]),
			.side_i  (nside[g]),
			.valid_q (nv[g+1]),
			.sn_q    (nsn[g+1]),
			.k_q     (nk[g+1]),
			.side_q  (nside[g+1])
		);
	end

	// Square root chain.
	logic [ROOT_STEPS:0]              rv;
	logic [ROOT_STEPS:0][SQ_W-1:0]    rsn;
	logic [ROOT_STEPS:0][REM_W-1:0]   rrem;
	logic [ROOT_STEPS:0][ROOT_W-1:0]  rroot;
	logic [ROOT_STEPS:0][SIDE1_W-1:0] rside;

	assign rv[0]    = nv[NORM_STEPS];
	assign rsn[0]   = nsn[NORM_STEPS];
	assign rrem[0]  = '0;
	assign rroot[0] = '0;
	assign rside[0] = {nside[NORM_STEPS], nk[NORM_STEPS]};

	for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
		vll_root_cell #(.SIDE_W(SIDE1_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.valid_i (rv[g]),
			.sn_i    (rsn[g]),
			.rem_i   (rrem[g]),
			.root_i  (rroot[g]),
			.side_i  (rside[g]),
			.valid_q (rv[g+1]),
			.sn_q    (rsn[g+1]),
			.rem_q   (rrem[g+1]),
			.root_q  (rroot[g+1]),
			.side_q  (rside[g+1])
		);
	end

	// Stage 6: numerators (magnitude shifted by k, times target).
	logic [LANES-1:0][CB-1:0] r_raw, r_mag;
	logic [LANES-1:0]         r_neg;
	act_t                     r_act;
	logic [LEN_W-1:0]         r_tgt;
	logic [K_W-1:0]           r_k;
	logic                     v_s6, v_s7;
	logic [LANES-1:0][NUM_W-1:0] num_s6;
	logic [ROOT_W-1:0]        len_s6;
	logic [SIDE2_W-1:0]       side2_s6, side2_s7;

	assign {r_raw, r_mag, r_neg, r_act, r_tgt, r_k} = rside[ROOT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s6 <= rv[ROOT_STEPS];
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s6   <= rroot[ROOT_STEPS];
			side2_s6 <= {r_raw, r_neg, r_act};
			for (int i = 0; i < LANES; i++) begin
				num_s6[i] <= NUM_W'(ROOT_W'(r_mag[i]) << r_k) * NUM_W'(r_tgt);
			end
		end
	end

	// Stage 7: rounded dividends and divisor; quotient fits in 17 bits.
	logic [LANES-1:0][DVD_W-1:0] dvd;
	lane_rem_t                   rem_s7;
	lane_q_t                     lo_s7;
	logic [DVS_W-1:0]            dvs_s7;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			dvd[i] = {num_s6[i], 1'b0} + DVD_W'(len_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvs_s7   <= {len_s6, 1'b0};
			side2_s7 <= side2_s6;
			for (int i = 0; i < LANES; i++) begin
				rem_s7[i] <= dvd[i][DVD_W-1:Q_W];
				lo_s7[i]  <= dvd[i][Q_W-1:0];
			end
		end
	end

	// Quotient chain.
	logic [Q_W:0]              dv;
	logic [Q_W:0][DVS_W-1:0]   ddvs;
	lane_rem_t                 drem  [Q_W+1];
	lane_q_t                   dlo   [Q_W+1];
	lane_q_t                   dquo  [Q_W+1];
	logic [Q_W:0][SIDE2_W-1:0] dside;

	assign dv[0]    = v_s7;
	assign ddvs[0]  = dvs_s7;
	assign drem[0]  = rem_s7;
	assign dlo[0]   = lo_s7;
	assign dquo[0]  = '0;
	assign dside[0] = side2_s7;

	for (genvar g = 0; g < Q_W; g++) begin : g_div
		vll_div_cell #(.SIDE_W(SIDE2_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.valid_i (dv[g]),
			.dvs_i   (ddvs[g]),
			.rem_i   (drem[g]),
			.lo_i    (dlo[g]),
			.quo_i   (dquo[g]),
			.side_i  (dside[g]),
			.valid_q (dv[g+1]),
			.dvs_q   (ddvs[g+1]),
			.rem_q   (drem[g+1]),
			.lo_q    (dlo[g+1]),
			.quo_q   (dquo[g+1]),
			.side_q  (dside[g+1])
		);
	end

	// Output stage: saturate, restore sign, or pass the input through.
	logic [LANES-1:0][CB-1:0] d_raw;
	logic [LANES-1:0]         d_neg;
	act_t                     d_act;
	logic [LANES-1:0][CB-1:0] res_c;
	logic [LANES-1:0]         clip_c;
	logic [LANES-1:0][LIM_W-1:0] mag_c;
	logic [LANES-1:0][LIM_W-1:0] lim_c;
	logic [LANES-1:0][CB-1:0] res_q;
	act_t                     act_q;
	logic                     sat_q;

	assign {d_raw, d_neg, d_act} = dside[Q_W];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lim_c[i]  = (LIM_W'(1) << (CB - 1)) - LIM_W'(!d_neg[i]);
			clip_c[i] = LIM_W'(dquo[Q_W][i]) > lim_c[i];
			mag_c[i]  = clip_c[i] ? lim_c[i] : LIM_W'(dquo[Q_W][i]);
			if (d_act == ACT_SHORTEN || d_act == ACT_LENGTHEN) begin
				res_c[i] = d_neg[i] ? CB'(-mag_c[i]) : CB'(mag_c[i]);
			end else begin
				res_c[i] = d_raw[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
			act_q <= d_act;
			sat_q <= (d_act == ACT_SHORTEN || d_act == ACT_LENGTHEN) && (clip_c != '0);
		end
	end

	assign out_x     = res_q[0];
	assign out_y     = res_q[1];
	assign out_z     = res_q[2];
	assign out_w     = res_q[3];
	assign action    = act_q;
	assign saturated = sat_q;

endmodule

/* hw/rtl/vll_checker.sv */
// ----------------------------------------------------------------------------
// vll_checker: port-level checks of the vector length limiter
// Watches the handshakes and result codes; bound to the top level.
// ----------------------------------------------------------------------------
module vll_checker #(
	parameter int COMPONENT_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [COMPONENT_BITS-1:0] out_x,
	input logic signed [COMPONENT_BITS-1:0] out_y,
	input logic signed [COMPONENT_BITS-1:0] out_z,
	input logic signed [COMPONENT_BITS-1:0] out_w,
	input logic [vll_pkg::ACT_W-1:0]      action,
	input logic                          saturated
);
	import vll_pkg::*;

	// A held result beat stays valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// The input side only stalls behind a held result.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// Unscaled results never report clipping.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_KEEP || action == ACT_ZERO) |-> !saturated)
		else $error("saturation flagged without scaling");

	// The zero-vector code comes only with a zero vector.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_ZERO |->
			out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0)
		else $error("zero-vector code on a nonzero vector");

endmodule

bind vec4_length_limiter vll_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_vll_checker (.*);
